/* rtl/core/preproc_line_marker_rewriter_defines.svh */
// Assertion macros shared by the line marker rewriter RTL.
`ifndef PREPROC_LINE_MARKER_REWRITER_DEFINES_SVH
`define PREPROC_LINE_MARKER_REWRITER_DEFINES_SVH
`ifndef SYNTH
// Check that post holds in the same cycle as pre.
`define PLMR_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Check that post holds in the cycle after pre.
`define PLMR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define PLMR_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg)
`define PLMR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

/* rtl/core/plmr_pkg.sv */
package plmr_pkg;

    localparam logic [1:0] OUTC_RUN  = 2'd0;
    localparam logic [1:0] OUTC_OK   = 2'd1;
    localparam logic [1:0] OUTC_FAIL = 2'd2;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam int HEAD_LEN = 6;

    function automatic logic [7:0] head_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h23;
            3'd1:    ch = 8'h6C;
            3'd2:    ch = 8'h69;
            3'd3:    ch = 8'h6E;
            3'd4:    ch = 8'h65;
            default: ch = CH_SP;
        endcase
        return ch;
    endfunction

    typedef enum logic [3:0] {
        PH_NAME   = 4'b0001,
        PH_DIGITS = 4'b0010,
        PH_TEXT   = 4'b0100,
        PH_FAILED = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        SRC_HEAD,
        SRC_DIG,
        SRC_SP,
        SRC_QUOTE,
        SRC_NAME,
        SRC_NL
    } t_src;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic [1:0] outcome;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic take;
        logic rd;
        logic idx_clr;
        logic idx_inc;
        logic emit;
        t_src src;
        logic last;
        logic busy;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic colon;
        logic len_diff;
        logic len_zero;
        logic dig_zero;
        logic cmp_ne;
        logic head_last;
        logic dig_last;
        logic name_last;
    } t_stat;

endpackage

/* rtl/core/plmr_if.sv */
interface plmr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface plmr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       has_char;
    logic [1:0] outcome;
    logic       last;

    modport source (output valid, output out_char, output has_char, output outcome,
                    output last, input ready);
    modport sink (input valid, input out_char, input has_char, input outcome,
                  input last, output ready);
endinterface

/* rtl/core/preproc_line_marker_rewriter.sv */
// Channel   Dir  Modport  Payload                               Beat taken when
// i_in      in   sink     in_byte[7:0], end_of_input            valid && ready
// o_out     out  source   out_char[7:0], has_char, outcome[1:0], last  valid && ready
//
// A byte that yields at most one beat is taken back to back, whenever the
// output register is empty or drained in the same cycle.
// A colon that ends the number compares names, a read and a check state per byte,
// if the length is unchanged and non-zero; a name change then emits the head,
// D digits, space, quoted L name bytes and newline via registered RAM reads.
// Synchronous active-low reset; no clearing pass. Output stalls hold the
// output register and block new input.
`include "preproc_line_marker_rewriter_defines.svh"

module preproc_line_marker_rewriter #(
    parameter int NAME_MAX_CHARS = 30,
    parameter int DIGITS_MAX     = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    plmr_in_if.sink           i_in,
    plmr_out_if.source        o_out
);

    plmr_pkg::t_cmd  cmd;
    plmr_pkg::t_stat stat;
    plmr_pkg::t_beat out_beat;
    logic            in_ready;
    logic            out_valid;

    plmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    plmr_dp #(
        .NAME_MAX_CHARS (NAME_MAX_CHARS),
        .DIGITS_MAX     (DIGITS_MAX)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in.valid),
        .i_in_byte      (i_in.in_byte),
        .i_end_of_input (i_in.end_of_input),
        .i_out_ready    (o_out.ready),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (out_valid),
        .o_out_beat     (out_beat)
    );

    assign i_in.ready     = in_ready;
    assign o_out.valid    = out_valid;
    assign o_out.out_char = out_beat.out_char;
    assign o_out.has_char = out_beat.has_char;
    assign o_out.outcome  = out_beat.outcome;
    assign o_out.last     = out_beat.last;

    `PLMR_ASSERT_NOW(a_busy_blocks_input, i_clk, i_rst_n, cmd.busy, !i_in.ready, "input ready while marker busy")
    `PLMR_ASSERT_NEXT(a_colon_starts_marker, i_clk, i_rst_n, cmd.take && stat.colon && stat.len_diff, cmd.busy, "name change did not start marker")
    `PLMR_ASSERT_NOW(a_status_is_final, i_clk, i_rst_n, o_out.valid && !o_out.has_char, o_out.last && (o_out.outcome != plmr_pkg::OUTC_RUN), "status beat not final")
    `PLMR_ASSERT_NOW(a_char_is_running, i_clk, i_rst_n, o_out.valid && o_out.has_char, o_out.outcome == plmr_pkg::OUTC_RUN, "char beat with end outcome")

endmodule

/* rtl/core/plmr_ram.sv */
module plmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 30,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/plmr_ctrl.sv */
module plmr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  plmr_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output plmr_pkg::t_cmd  o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_CMP_RD = 12'b000000000010,
        S_CMP_CK = 12'b000000000100,
        S_HEAD   = 12'b000000001000,
        S_DIG_RD = 12'b000000010000,
        S_DIG_WR = 12'b000000100000,
        S_SP     = 12'b000001000000,
        S_QO     = 12'b000010000000,
        S_NM_RD  = 12'b000100000000,
        S_NM_WR  = 12'b001000000000,
        S_QC     = 12'b010000000000,
        S_NL     = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   in_ready;
    logic   free;

    assign free       = i_stat.out_free;
    assign in_ready   = (r_state == S_IDLE) && free;
    assign o_in_ready = in_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.src     = plmr_pkg::SRC_HEAD;
        o_cmd.busy    = (r_state != S_IDLE);
        o_cmd.take    = i_in_valid && in_ready;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.take && i_stat.colon) begin
                    o_cmd.idx_clr = 1'b1;
                    if (i_stat.len_diff) begin
                        n_state = S_HEAD;
                    end else if (!i_stat.len_zero) begin
                        n_state = S_CMP_RD;
                    end
                end
            end
            S_CMP_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CMP_CK;
            end
            S_CMP_CK: begin
                if (i_stat.cmp_ne) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_HEAD;
                end else if (i_stat.name_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_CMP_RD;
                end
            end
            S_HEAD: begin
                o_cmd.src = plmr_pkg::SRC_HEAD;
                if (free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.head_last) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = i_stat.dig_zero ? S_SP : S_DIG_RD;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_DIG_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DIG_WR;
            end
            S_DIG_WR: begin
                o_cmd.src = plmr_pkg::SRC_DIG;
                if (free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.dig_last) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_SP;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_DIG_RD;
                    end
                end
            end
            S_SP: begin
                o_cmd.src = plmr_pkg::SRC_SP;
                if (free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_QO;
                end
            end
            S_QO: begin
                o_cmd.src = plmr_pkg::SRC_QUOTE;
                if (free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.len_zero ? S_QC : S_NM_RD;
                end
            end
            S_NM_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_NM_WR;
            end
            S_NM_WR: begin
                o_cmd.src = plmr_pkg::SRC_NAME;
                if (free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.name_last) begin
                        n_state = S_QC;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_NM_RD;
                    end
                end
            end
            S_QC: begin
                o_cmd.src = plmr_pkg::SRC_QUOTE;
                if (free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_NL;
                end
            end
            S_NL: begin
                o_cmd.src = plmr_pkg::SRC_NL;
                if (free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/core/plmr_dp.sv */
module plmr_dp #(
    parameter int NAME_MAX_CHARS = 30,
    parameter int DIGITS_MAX     = 18
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [7:0]      i_in_byte,
    input  logic            i_end_of_input,
    input  logic            i_out_ready,
    input  plmr_pkg::t_cmd  i_cmd,
    output plmr_pkg::t_stat o_stat,
    output logic            o_out_valid,
    output plmr_pkg::t_beat o_out_beat
);

    localparam int NL_W    = $clog2(NAME_MAX_CHARS + 1);
    localparam int NA_W    = (NAME_MAX_CHARS > 1) ? $clog2(NAME_MAX_CHARS) : 1;
    localparam int DL_W    = $clog2(DIGITS_MAX + 1);
    localparam int DA_W    = (DIGITS_MAX > 1) ? $clog2(DIGITS_MAX) : 1;
    localparam int IDX_MAX = (NAME_MAX_CHARS > DIGITS_MAX) ? NAME_MAX_CHARS : DIGITS_MAX;
    localparam int IDX_TOP = (IDX_MAX > plmr_pkg::HEAD_LEN) ? IDX_MAX : plmr_pkg::HEAD_LEN;
    localparam int IDX_W   = $clog2(IDX_TOP + 1);

    plmr_pkg::t_phase r_phase, n_phase;
    logic [NL_W-1:0]  r_name_len, n_name_len;
    logic [NL_W-1:0]  r_prev_len, n_prev_len;
    logic [DL_W-1:0]  r_dig_cnt, n_dig_cnt;
    logic             r_bs, n_bs;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] idx_nxt;
    logic             r_out_vld;
    plmr_pkg::t_beat  r_out_beat;

    logic             beat_vld;
    plmr_pkg::t_beat  beat;
    plmr_pkg::t_beat  emit_beat;
    logic             name_we;
    logic             dig_we;
    logic             is_blank;
    logic             is_digit;
    logic             out_free;
    logic [7:0]       name_rdata;
    logic [7:0]       prev_rdata;
    logic [3:0]       dig_rdata;
    logic             prev_we;

    assign is_blank = (i_in_byte == plmr_pkg::CH_SP) || (i_in_byte == plmr_pkg::CH_TAB);
    assign is_digit = (i_in_byte >= plmr_pkg::CH_ZERO) && (i_in_byte <= plmr_pkg::CH_NINE);
    assign out_free = !r_out_vld || i_out_ready;
    assign idx_nxt  = IDX_W'(r_idx + IDX_W'(1));
    assign prev_we  = i_cmd.emit && (i_cmd.src == plmr_pkg::SRC_NAME);

    always_comb begin
        n_phase    = r_phase;
        n_name_len = r_name_len;
        n_prev_len = r_prev_len;
        n_dig_cnt  = r_dig_cnt;
        n_bs       = r_bs;
        beat_vld   = 1'b0;
        beat       = '{out_char: 8'h00, has_char: 1'b0,
                       outcome: plmr_pkg::OUTC_FAIL, last: 1'b1};
        name_we    = 1'b0;
        dig_we     = 1'b0;
        if (i_cmd.take) begin
            if (i_end_of_input) begin
                if (r_phase != plmr_pkg::PH_FAILED) begin
                    beat_vld = 1'b1;
                    if ((r_phase == plmr_pkg::PH_DIGITS) ||
                        ((r_phase == plmr_pkg::PH_NAME) && (r_name_len != '0))) begin
                        beat.outcome = plmr_pkg::OUTC_FAIL;
                    end else begin
                        beat.outcome = plmr_pkg::OUTC_OK;
                    end
                end
                n_phase    = plmr_pkg::PH_NAME;
                n_name_len = '0;
                n_prev_len = '0;
                n_dig_cnt  = '0;
                n_bs       = 1'b0;
            end else begin
                unique case (r_phase)
                    plmr_pkg::PH_NAME: begin
                        if (i_in_byte == plmr_pkg::CH_NL) begin
                            beat_vld = 1'b1;
                            if (r_name_len == '0) begin
                                beat.out_char = i_in_byte;
                                beat.has_char = 1'b1;
                                beat.outcome  = plmr_pkg::OUTC_RUN;
                            end else begin
                                n_phase = plmr_pkg::PH_FAILED;
                            end
                        end else if (is_blank) begin
                            n_phase   = plmr_pkg::PH_DIGITS;
                            n_dig_cnt = '0;
                        end else if (r_name_len >= NL_W'(NAME_MAX_CHARS)) begin
                            beat_vld = 1'b1;
                            n_phase  = plmr_pkg::PH_FAILED;
                        end else begin
                            name_we    = 1'b1;
                            n_name_len = NL_W'(r_name_len + NL_W'(1));
                        end
                    end
                    plmr_pkg::PH_DIGITS: begin
                        if (i_in_byte == plmr_pkg::CH_COLON) begin
                            n_phase    = plmr_pkg::PH_TEXT;
                            n_bs       = 1'b0;
                            n_prev_len = r_name_len;
                        end else if (is_blank) begin
                            n_phase = r_phase;
                        end else if (is_digit && (r_dig_cnt < DL_W'(DIGITS_MAX))) begin
                            dig_we    = 1'b1;
                            n_dig_cnt = DL_W'(r_dig_cnt + DL_W'(1));
                        end else begin
                            beat_vld = 1'b1;
                            n_phase  = plmr_pkg::PH_FAILED;
                        end
                    end
                    plmr_pkg::PH_TEXT: begin
                        beat_vld      = 1'b1;
                        beat.out_char = i_in_byte;
                        beat.has_char = 1'b1;
                        beat.outcome  = plmr_pkg::OUTC_RUN;
                        if ((i_in_byte == plmr_pkg::CH_NL) && !r_bs) begin
                            n_phase    = plmr_pkg::PH_NAME;
                            n_name_len = '0;
                        end
                        n_bs = (i_in_byte == plmr_pkg::CH_BSLASH);
                    end
                    plmr_pkg::PH_FAILED: begin
                        n_phase = r_phase;
                    end
                    default: begin
                        n_phase = plmr_pkg::PH_FAILED;
                    end
                endcase
            end
        end
    end

    always_comb begin
        emit_beat = '{out_char: 8'h00, has_char: 1'b1,
                      outcome: plmr_pkg::OUTC_RUN, last: i_cmd.last};
        case (i_cmd.src)
            plmr_pkg::SRC_HEAD:  emit_beat.out_char = plmr_pkg::head_char(r_idx[2:0]);
            plmr_pkg::SRC_DIG:   emit_beat.out_char = plmr_pkg::CH_ZERO + {4'h0, dig_rdata};
            plmr_pkg::SRC_SP:    emit_beat.out_char = plmr_pkg::CH_SP;
            plmr_pkg::SRC_QUOTE: emit_beat.out_char = plmr_pkg::CH_QUOTE;
            plmr_pkg::SRC_NAME:  emit_beat.out_char = name_rdata;
            plmr_pkg::SRC_NL:    emit_beat.out_char = plmr_pkg::CH_NL;
            default:             emit_beat.out_char = plmr_pkg::CH_NL;
        endcase
    end

    plmr_ram #(.WIDTH(8), .DEPTH(NAME_MAX_CHARS), .AW(NA_W)) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (r_name_len[NA_W-1:0]),
        .i_wdata (i_in_byte),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx[NA_W-1:0]),
        .o_rdata (name_rdata)
    );

    plmr_ram #(.WIDTH(8), .DEPTH(NAME_MAX_CHARS), .AW(NA_W)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (r_idx[NA_W-1:0]),
        .i_wdata (name_rdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx[NA_W-1:0]),
        .o_rdata (prev_rdata)
    );

    plmr_ram #(.WIDTH(4), .DEPTH(DIGITS_MAX), .AW(DA_W)) u_dig_ram (
        .i_clk   (i_clk),
        .i_we    (dig_we),
        .i_waddr (r_dig_cnt[DA_W-1:0]),
        .i_wdata (i_in_byte[3:0]),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx[DA_W-1:0]),
        .o_rdata (dig_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= plmr_pkg::PH_NAME;
            r_name_len <= '0;
            r_prev_len <= '0;
            r_dig_cnt  <= '0;
            r_bs       <= 1'b0;
            r_idx      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_name_len <= n_name_len;
            r_prev_len <= n_prev_len;
            r_dig_cnt  <= n_dig_cnt;
            r_bs       <= n_bs;
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= idx_nxt;
            end
            if (beat_vld || i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat_vld) begin
            r_out_beat <= beat;
        end else if (i_cmd.emit) begin
            r_out_beat <= emit_beat;
        end
    end

    assign o_stat.out_free  = out_free;
    assign o_stat.colon     = i_in_valid && !i_end_of_input &&
                              (r_phase == plmr_pkg::PH_DIGITS) &&
                              (i_in_byte == plmr_pkg::CH_COLON);
    assign o_stat.len_diff  = (r_name_len != r_prev_len);
    assign o_stat.len_zero  = (r_name_len == '0);
    assign o_stat.dig_zero  = (r_dig_cnt == '0);
    assign o_stat.cmp_ne    = (name_rdata != prev_rdata);
    assign o_stat.head_last = (r_idx == IDX_W'(plmr_pkg::HEAD_LEN - 1));
    assign o_stat.dig_last  = (idx_nxt == IDX_W'(r_dig_cnt));
    assign o_stat.name_last = (idx_nxt == IDX_W'(r_name_len));

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out_beat;

endmodule
